// File: sv/ceoe_pkg.sv
// ----------------------------------------------------------------------------
// ceoe_pkg: shared types and constants for the comment extractor
// Transfer payloads, queue entry layout, result kinds and character codes.
// ----------------------------------------------------------------------------
package ceoe_pkg;

   // input item kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   // result kinds
   localparam logic [1:0] OUT_BYTE    = 2'd0;
   localparam logic [1:0] OUT_END     = 2'd1;
   localparam logic [1:0] OUT_DISCARD = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SEVEN   = 8'h37;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // input transfer payload
   typedef struct packed {
      logic       kind;
      logic [7:0] in_byte;
   } req_type;

   // output transfer payload
   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // one result without its position flag
   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
   } res_type;

   // queue entry: one or two results caused by one input item
   typedef struct packed {
      logic    two;
      res_type r0;
      res_type r1;
   } entry_type;

   // parser mode, one-hot
   typedef enum logic [2:0] {
      MODE_OUTSIDE = 3'b001,
      MODE_COMMENT = 3'b010,
      MODE_ESCAPE  = 3'b100
   } mode_type;

endpackage

// File: sv/ceoe_front.sv
// ----------------------------------------------------------------------------
// ceoe_front: parser state and result classification
// Takes one input item per cycle while the queue has room, updates the
// comment/escape state and builds the queue entry holding the item's results.
// ----------------------------------------------------------------------------
module ceoe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  ceoe_pkg::req_type  req,
   output logic               push,
   output ceoe_pkg::entry_type entry
);

   ceoe_pkg::mode_type mode_ff, mode_in;
   logic [14:0]        oct_ff, oct_in;
   logic               bad_ff, bad_in;
   logic               has_ff, has_in;

   // classification and next state
   always_comb begin
      logic [7:0] c;
      logic       as_comment;
      logic [1:0] cnt;
      ceoe_pkg::res_type res [2];
      c          = req.in_byte;
      as_comment = 1'b0;
      cnt        = 2'd0;
      res[0]     = '0;
      res[1]     = '0;
      mode_in    = mode_ff;
      oct_in     = oct_ff;
      bad_in     = bad_ff;
      has_in     = has_ff;

      if (req.kind == ceoe_pkg::KIND_EOS) begin
         if (mode_ff != ceoe_pkg::MODE_OUTSIDE && has_ff) begin
            res[0] = '{out_kind: ceoe_pkg::OUT_DISCARD, out_byte: 8'd0};
            cnt    = 2'd1;
         end
         mode_in = ceoe_pkg::MODE_OUTSIDE;
         oct_in  = '0;
         bad_in  = 1'b0;
         has_in  = 1'b0;
      end else begin
         case (mode_ff)
            ceoe_pkg::MODE_ESCAPE: begin
               if (c == ceoe_pkg::CHAR_BSLASH) begin
                  res[0]  = '{out_kind: ceoe_pkg::OUT_BYTE, out_byte: ceoe_pkg::CHAR_BSLASH};
                  cnt     = 2'd1;
                  has_in  = 1'b1;
                  mode_in = ceoe_pkg::MODE_COMMENT;
                  oct_in  = '0;
                  bad_in  = 1'b0;
               end else if (c inside {[ceoe_pkg::CHAR_ZERO:ceoe_pkg::CHAR_NINE]}) begin
                  // octal digit gathering; overflow when any of the top three bits is set
                  if (c > ceoe_pkg::CHAR_SEVEN) begin
                     bad_in = 1'b1;
                  end else if (!bad_ff) begin
                     if (|oct_ff[14:12]) begin
                        bad_in = 1'b1;
                     end else begin
                        oct_in = {oct_ff[11:0], c[2:0]};
                     end
                  end
               end else begin
                  res[0]     = '{out_kind: ceoe_pkg::OUT_BYTE,
                                 out_byte: bad_ff ? 8'd0 : oct_ff[7:0]};
                  cnt        = 2'd1;
                  has_in     = 1'b1;
                  mode_in    = ceoe_pkg::MODE_COMMENT;
                  oct_in     = '0;
                  bad_in     = 1'b0;
                  as_comment = 1'b1;
               end
            end
            ceoe_pkg::MODE_COMMENT: begin
               as_comment = 1'b1;
            end
            default: begin
               if (c == ceoe_pkg::CHAR_PERCENT) begin
                  mode_in = ceoe_pkg::MODE_COMMENT;
                  has_in  = 1'b0;
                  oct_in  = '0;
                  bad_in  = 1'b0;
               end
            end
         endcase

         // ordinary comment byte, possibly after an escape ended
         if (as_comment) begin
            if (c inside {ceoe_pkg::CHAR_LF, ceoe_pkg::CHAR_CR}) begin
               if (has_in) begin
                  res[cnt[0]] = '{out_kind: ceoe_pkg::OUT_END, out_byte: 8'd0};
                  cnt         = cnt + 2'd1;
               end
               has_in  = 1'b0;
               mode_in = ceoe_pkg::MODE_OUTSIDE;
               oct_in  = '0;
               bad_in  = 1'b0;
            end else if (c == ceoe_pkg::CHAR_BSLASH) begin
               mode_in = ceoe_pkg::MODE_ESCAPE;
               oct_in  = '0;
               bad_in  = 1'b0;
            end else begin
               res[cnt[0]] = '{out_kind: ceoe_pkg::OUT_BYTE, out_byte: c};
               cnt         = cnt + 2'd1;
               has_in      = 1'b1;
            end
         end
      end

      push      = take && (cnt != 2'd0);
      entry.two = cnt[1];
      entry.r0  = res[0];
      entry.r1  = res[1];
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ceoe_pkg::MODE_OUTSIDE;
         oct_ff  <= '0;
         bad_ff  <= 1'b0;
         has_ff  <= 1'b0;
      end else if (take) begin
         mode_ff <= mode_in;
         oct_ff  <= oct_in;
         bad_ff  <= bad_in;
         has_ff  <= has_in;
      end
   end

endmodule

// File: sv/ceoe_queue.sv
// ----------------------------------------------------------------------------
// ceoe_queue: small FIFO between front and back
// Holds queue entries so the parser and the result serializer stall apart.
// ----------------------------------------------------------------------------
module ceoe_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ceoe_pkg::entry_type push_entry,
   input  logic                pop,
   output ceoe_pkg::entry_type head,
   output logic                empty,
   output logic                full
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   ceoe_pkg::entry_type entries_ff [DEPTH];
   logic [IW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]       count_ff, count_in;

   assign empty = (count_ff == CW'(0));
   assign full  = (count_ff == CW'(DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   // storage, no reset on payload
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + IW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + IW'(1);
         end
      end
   end

endmodule

// File: sv/ceoe_back.sv
// ----------------------------------------------------------------------------
// ceoe_back: result serializer with output register
// Sends the one or two results of each queue entry, marking the final one.
// ----------------------------------------------------------------------------
module ceoe_back (
   input  logic                clock,
   input  logic                reset,
   input  ceoe_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ceoe_pkg::rsp_type   rsp_data
);

   logic              phase_ff;
   logic              valid_ff;
   ceoe_pkg::rsp_type data_ff, data_in;
   logic              load;

   // output register free or being drained this cycle
   assign load = !empty && (!valid_ff || rsp_ready);

   always_comb begin
      ceoe_pkg::res_type sel;
      sel              = phase_ff ? head.r1 : head.r0;
      data_in.out_kind = sel.out_kind;
      data_in.out_byte = sel.out_byte;
      data_in.last     = phase_ff || !head.two;
   end

   assign pop       = load && data_in.last;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            phase_ff <= !data_in.last;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

// File: sv/comment_extractor_octal_escape_core.sv
// ----------------------------------------------------------------------------
// comment_extractor_octal_escape_core: percent-comment text extractor
// Streams out the text of percent comments with octal escape decoding.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one byte (kind = data) or an end-of-stream mark per transfer.
//   rsp channel: comment bytes, comment-end markers and discard markers; the
//   final result caused by one input transfer carries last = 1.
//   An accepted input is written to the queue, then its first result is loaded
//   into the output register. The front parser takes one input per cycle while
//   the queue has room; the back serializer emits one result per cycle while
//   the receiver is ready, so an input with two results (an escape closed by
//   another byte) holds the back until both are sent. The front keeps taking
//   inputs while earlier results wait in the queue and the output register.
//   QUEUE_DEPTH (2 or more) entries buffer the front from the back; inputs
//   with no result never enter the queue.
//   Reset returns the parser to outside-comment and empties the queue and
//   output register. When the receiver stalls, results hold in the output
//   register, the queue fills, and req_ready drops once it is full.
// ----------------------------------------------------------------------------
module comment_extractor_octal_escape_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ceoe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ceoe_pkg::rsp_type rsp_data
);

   logic                take;
   logic                push;
   logic                pop;
   logic                empty;
   logic                full;
   ceoe_pkg::entry_type push_entry;
   ceoe_pkg::entry_type head;

   assign req_ready = !full;
   assign take      = req_valid && req_ready;

   ceoe_front u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .push  (push),
      .entry (push_entry)
   );

   ceoe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   ceoe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/ceoe_checker.sv
// ----------------------------------------------------------------------------
// ceoe_checker: port-level checks for the comment extractor
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module ceoe_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ceoe_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // nothing pending right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // only the three defined result kinds appear
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_kind == ceoe_pkg::OUT_BYTE
                 || rsp_data.out_kind == ceoe_pkg::OUT_END
                 || rsp_data.out_kind == ceoe_pkg::OUT_DISCARD)
      else $error("undefined result kind");

   // markers carry a zero byte
   a_marker_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind != ceoe_pkg::OUT_BYTE |-> rsp_data.out_byte == 8'd0)
      else $error("marker with nonzero byte");

   // end and discard markers always close their input's results
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind != ceoe_pkg::OUT_BYTE |-> rsp_data.last)
      else $error("marker not last");

endmodule

bind comment_extractor_octal_escape_core ceoe_checker u_ceoe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/tb_comment_extractor_octal_escape_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_comment_extractor_octal_escape_core: self-checking bench for the core
// Drives byte streams made mostly of percent comments with random text and
// octal escapes, plus noise, under several sender/receiver idle mixes. A
// scoreboard tracks the parser state, predicts every result and checks each
// rsp transfer in order, field by field.
// ----------------------------------------------------------------------------
module tb_comment_extractor_octal_escape_core;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer before giving up
   localparam int DRAIN_CYCLES = 10;    // quiet cycles after the last result
   localparam int PHASE_ITEMS  = 250;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the comment parser and holds the results still owed
   // -------------------------------------------------------------------------
   class comment_scoreboard;
      ceoe_pkg::mode_type mode;
      logic [14:0]        octal_acc;
      bit                 octal_bad;
      bit                 has_bytes;
      ceoe_pkg::rsp_type  owed[$];
      int                 errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         mode      = ceoe_pkg::MODE_OUTSIDE;
         has_bytes = 1'b0;
         octal_acc = '0;
         octal_bad = 1'b0;
      endfunction

      // predict the results of one accepted input transfer
      function void note_input(ceoe_pkg::req_type item);
         ceoe_pkg::rsp_type made[2];
         int                n;
         bit                as_comment;
         logic [7:0]        c;
         logic [7:0]        d;
         int                nv;
         n          = 0;
         as_comment = 1'b0;
         c          = item.in_byte;
         if (item.kind == ceoe_pkg::KIND_EOS) begin
            if (mode != ceoe_pkg::MODE_OUTSIDE && has_bytes) begin
               made[n] = '{out_kind: ceoe_pkg::OUT_DISCARD, out_byte: 8'h00,
                           last: 1'b0};
               n++;
            end
            restart();
         end else begin
            case (mode)
               ceoe_pkg::MODE_ESCAPE: begin
                  if (c == ceoe_pkg::CHAR_BSLASH) begin
                     // escape closed by a second backslash: literal backslash
                     made[n] = '{out_kind: ceoe_pkg::OUT_BYTE,
                                 out_byte: ceoe_pkg::CHAR_BSLASH, last: 1'b0};
                     n++;
                     has_bytes = 1'b1;
                     mode      = ceoe_pkg::MODE_COMMENT;
                     octal_acc = '0;
                     octal_bad = 1'b0;
                  end else if (c >= ceoe_pkg::CHAR_ZERO && c <= ceoe_pkg::CHAR_NINE) begin
                     d = c - ceoe_pkg::CHAR_ZERO;
                     if (d >= 8) begin
                        octal_bad = 1'b1;
                     end else if (!octal_bad) begin
                        nv = int'(octal_acc) * 8 + int'(d);
                        if (nv > 32767) octal_bad = 1'b1;
                        else octal_acc = nv[14:0];
                     end
                  end else begin
                     // any other byte decodes the escape, then is a comment byte
                     made[n] = '{out_kind: ceoe_pkg::OUT_BYTE,
                                 out_byte: octal_bad ? 8'h00 : octal_acc[7:0],
                                 last: 1'b0};
                     n++;
                     has_bytes  = 1'b1;
                     mode       = ceoe_pkg::MODE_COMMENT;
                     octal_acc  = '0;
                     octal_bad  = 1'b0;
                     as_comment = 1'b1;
                  end
               end
               ceoe_pkg::MODE_COMMENT: as_comment = 1'b1;
               default: begin
                  if (c == ceoe_pkg::CHAR_PERCENT) begin
                     mode      = ceoe_pkg::MODE_COMMENT;
                     has_bytes = 1'b0;
                     octal_acc = '0;
                     octal_bad = 1'b0;
                  end
               end
            endcase

            if (as_comment) begin
               if (c == ceoe_pkg::CHAR_LF || c == ceoe_pkg::CHAR_CR) begin
                  // end marker only for a comment that produced text
                  if (has_bytes) begin
                     made[n] = '{out_kind: ceoe_pkg::OUT_END, out_byte: 8'h00,
                                 last: 1'b0};
                     n++;
                  end
                  has_bytes = 1'b0;
                  mode      = ceoe_pkg::MODE_OUTSIDE;
                  octal_acc = '0;
                  octal_bad = 1'b0;
               end else if (c == ceoe_pkg::CHAR_BSLASH) begin
                  mode      = ceoe_pkg::MODE_ESCAPE;
                  octal_acc = '0;
                  octal_bad = 1'b0;
               end else begin
                  made[n] = '{out_kind: ceoe_pkg::OUT_BYTE, out_byte: c, last: 1'b0};
                  n++;
                  has_bytes = 1'b1;
               end
            end
         end

         if (n > 0) made[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) owed.push_back(made[i]);
      endfunction

      // compare one rsp transfer with the oldest owed result
      function void check_result(ceoe_pkg::rsp_type got);
         ceoe_pkg::rsp_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d byte %02h last %0d",
                     $time, got.out_kind, got.out_byte, got.last);
            errors++;
         end else begin
            want = owed.pop_front();
            if (got.out_kind !== want.out_kind) begin
               $display("%0t: out_kind mismatch, expected %0d, actual %0d",
                        $time, want.out_kind, got.out_kind);
               errors++;
            end
            if (got.out_byte !== want.out_byte) begin
               $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                        $time, want.out_byte, got.out_byte);
               errors++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last mismatch, expected %0d, actual %0d",
                        $time, want.last, got.last);
               errors++;
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and DUT
   // -------------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ceoe_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ceoe_pkg::rsp_type rsp_data;

   comment_scoreboard sb;
   ceoe_pkg::req_type stim[$];
   int                sender_idle_pct = 0;
   int                stall_pct       = 0;
   int                items_sent      = 0;
   int                quiet_cycles    = 0;

   comment_extractor_octal_escape_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // -------------------------------------------------------------------------
   // Monitor: score transfers, watchdog on a stuck interface
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_input(req_data);
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
            moved = 1'b1;
         end
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_comment_extractor_octal_escape_core failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function void push_data(logic [7:0] b);
      stim.push_back(ceoe_pkg::req_type'{kind: ceoe_pkg::KIND_DATA, in_byte: b});
   endfunction

   function void push_eos();
      stim.push_back(ceoe_pkg::req_type'{kind: ceoe_pkg::KIND_EOS,
                                         in_byte: 8'($urandom_range(255))});
   endfunction

   // printable text or a high byte, never a backslash or line break
   function logic [7:0] text_byte();
      logic [7:0] b;
      if ($urandom_range(9) == 0) return 8'($urandom_range(255, 128));
      b = 8'($urandom_range(126, 32));
      if (b == ceoe_pkg::CHAR_BSLASH) b = "a";
      return b;
   endfunction

   // mostly octal digits, now and then an 8 or 9
   function logic [7:0] escape_digit();
      if ($urandom_range(9) == 0) return ceoe_pkg::CHAR_ZERO + 8'($urandom_range(9, 8));
      return ceoe_pkg::CHAR_ZERO + 8'($urandom_range(7));
   endfunction

   // one random segment: mostly a well-formed comment line, sometimes noise
   function void gen_segment();
      int nb;
      if ($urandom_range(99) < 12) begin
         nb = $urandom_range(8, 1);
         for (int i = 0; i < nb; i++) begin
            if ($urandom_range(15) == 0) push_eos();
            else if ($urandom_range(3) == 0) begin
               case ($urandom_range(3))
                  0: push_data(ceoe_pkg::CHAR_PERCENT);
                  1: push_data(ceoe_pkg::CHAR_BSLASH);
                  2: push_data(ceoe_pkg::CHAR_LF);
                  default: push_data(ceoe_pkg::CHAR_CR);
               endcase
            end else push_data(8'($urandom_range(255)));
         end
      end else begin
         nb = $urandom_range(3);
         for (int i = 0; i < nb; i++) push_data(8'($urandom_range(255)));
         push_data(ceoe_pkg::CHAR_PERCENT);
         nb = $urandom_range(10);
         for (int i = 0; i < nb; i++) begin
            if ($urandom_range(3) == 0) begin
               push_data(ceoe_pkg::CHAR_BSLASH);
               // up to six digits so the value can overflow
               repeat ($urandom_range(6)) push_data(escape_digit());
               case ($urandom_range(3))
                  0: push_data(ceoe_pkg::CHAR_BSLASH);
                  1: push_data(text_byte());
                  default: ;  // closed by whatever follows
               endcase
            end else push_data(text_byte());
         end
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6: push_data(ceoe_pkg::CHAR_LF);
            7, 8, 9, 10, 11, 12, 13: push_data(ceoe_pkg::CHAR_CR);
            14, 15, 16: push_eos();
            default: ;  // comment runs on into the next segment
         endcase
      end
   endfunction

   // -------------------------------------------------------------------------
   // Drivers, entered and left at a falling edge
   // -------------------------------------------------------------------------
   task automatic send_item(ceoe_pkg::req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_stim();
      while (stim.size() != 0) send_item(stim.pop_front());
      req_valid <= 1'b0;
   endtask

   // hold the sender until every owed result has come out
   task automatic drain();
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty comment gets no end marker
      push_data(ceoe_pkg::CHAR_PERCENT);
      push_data(ceoe_pkg::CHAR_LF);
      // high byte, escape 101 closed by an ordinary byte
      push_data(ceoe_pkg::CHAR_PERCENT);
      push_data(8'hFF);
      push_data(ceoe_pkg::CHAR_BSLASH);
      push_data("1");
      push_data("0");
      push_data("1");
      push_data("B");
      // bad digit then backslash: literal backslash only
      push_data(ceoe_pkg::CHAR_BSLASH);
      push_data(ceoe_pkg::CHAR_NINE);
      push_data(ceoe_pkg::CHAR_BSLASH);
      // overflow: six sevens exceed the 15-bit limit
      push_data(ceoe_pkg::CHAR_BSLASH);
      repeat (6) push_data(ceoe_pkg::CHAR_SEVEN);
      push_data("x");
      // bad digit 8, escape closed by CR: zero byte then end marker
      push_data(ceoe_pkg::CHAR_BSLASH);
      push_data("8");
      push_data(ceoe_pkg::CHAR_CR);
      // empty escape gives zero, then unterminated comment at end of stream
      push_data(ceoe_pkg::CHAR_PERCENT);
      push_data(ceoe_pkg::CHAR_BSLASH);
      push_data("z");
      push_eos();
      // end of stream outside a comment, then a null byte
      push_eos();
      push_data(8'h00);
      send_stim();
      drain();

      // random phases with different idle mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 45; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 45; end
            default: begin sender_idle_pct = 34; stall_pct = 34; end
         endcase
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            gen_segment();
            send_stim();
         end
         drain();
      end

      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("tb_comment_extractor_octal_escape_core passed");
      end else begin
         $display("tb_comment_extractor_octal_escape_core failed");
      end
      $finish;
   end

endmodule
